// ----- design/pulse_width_rf_frame_receiver_assert.svh -----
// assertion macros shared by the pulse width frame receiver modules
`ifndef PULSE_WIDTH_RF_FRAME_RECEIVER_ASSERT_SVH
`define PULSE_WIDTH_RF_FRAME_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define PRFR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("prfr assertion failed");
// checked at every edge, reset included
`define PRFR_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("prfr assertion failed");
`else
`define PRFR_ASSERT(name, prop)
`define PRFR_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ----- design/prfr_pkg.sv -----
// types and constants of the pulse width frame receiver
package prfr_pkg;

  localparam int unsigned CNT_W     = 7;
  localparam int unsigned THR_W     = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned ADDR_W    = 20;
  localparam int unsigned ON_LSB    = 20;
  localparam int unsigned ON_W      = 4;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_WIN  = 3'd5;

  // register reset values
  localparam logic [THR_W-1:0] RST_SHORT_MIN  = 16'd110;
  localparam logic [THR_W-1:0] RST_LONG_MIN   = 16'd330;
  localparam logic [THR_W-1:0] RST_SYNC_MIN   = 16'd550;
  localparam logic [THR_W-1:0] RST_SYNC_MAX   = 16'd770;
  localparam logic [THR_W-1:0] RST_STOP_MIN   = 16'd1760;
  localparam logic [THR_W-1:0] RST_REPEAT_WIN = 16'd2000;

  localparam logic OP_EDGE    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;
  localparam logic LEVEL_FALL = 1'b0;

  typedef struct packed {
    logic              opcode;
    logic              edge_level;
    logic [TIME_W-1:0] edge_time_us;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic              frame_available;
    logic [ADDR_W-1:0] address;
    logic              turn_on;
  } out_item_t;

endpackage

// ----- design/prfr_core.sv -----
// edge classification, frame assembly and repeat suppression
module prfr_core #(
  parameter int unsigned MessageBits = 56,
  parameter int unsigned WrapCount   = 70
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [prfr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [prfr_pkg::THR_W-1:0]          cfg_data_i,
  input  logic                                item_valid_i,
  input  prfr_pkg::in_item_t                  item_i,
  output prfr_pkg::out_item_t                 result_o
);
  import prfr_pkg::*;

  `include "pulse_width_rf_frame_receiver_assert.svh"

  localparam logic [CNT_W-1:0] MsgCount  = CNT_W'(MessageBits);
  localparam logic [CNT_W-1:0] WrapValue = CNT_W'(WrapCount);

  logic [THR_W-1:0] short_min_q, long_min_q, sync_min_q, sync_max_q, stop_min_q, repeat_win_q;

  logic [MessageBits-1:0] frame_q, frame_d;
  logic [MessageBits-1:0] prev_frame_q, prev_frame_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d, cnt_wrap;
  logic [TIME_W-1:0]      prev_ms_q, prev_ms_d;
  logic [TIME_W-1:0]      prev_edge_q, prev_edge_d;
  logic                   avail_q, avail_d, avail_out;
  logic [TIME_W-1:0]      diff, age;
  logic                   in_range, is_sync, is_zero, is_stop, same_frame, repeat_hit;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_min_q  <= RST_SHORT_MIN;
      long_min_q   <= RST_LONG_MIN;
      sync_min_q   <= RST_SYNC_MIN;
      sync_max_q   <= RST_SYNC_MAX;
      stop_min_q   <= RST_STOP_MIN;
      repeat_win_q <= RST_REPEAT_WIN;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SHORT_MIN:  short_min_q  <= cfg_data_i;
        CFG_LONG_MIN:   long_min_q   <= cfg_data_i;
        CFG_SYNC_MIN:   sync_min_q   <= cfg_data_i;
        CFG_SYNC_MAX:   sync_max_q   <= cfg_data_i;
        CFG_STOP_MIN:   stop_min_q   <= cfg_data_i;
        CFG_REPEAT_WIN: repeat_win_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    diff       = item_i.edge_time_us - prev_edge_q;
    age        = item_i.now_ms - prev_ms_q;
    in_range   = (diff >= TIME_W'(short_min_q)) && (diff <= TIME_W'(sync_max_q));
    is_sync    = diff >= TIME_W'(sync_min_q);
    is_zero    = diff <= TIME_W'(long_min_q);
    is_stop    = diff >= TIME_W'(stop_min_q);
    same_frame = frame_q == prev_frame_q;
    repeat_hit = age < TIME_W'(repeat_win_q);
    cnt_wrap   = (cnt_q == WrapValue) ? '0 : cnt_q;

    frame_d      = frame_q;
    prev_frame_d = prev_frame_q;
    cnt_d        = cnt_q;
    prev_ms_d    = prev_ms_q;
    prev_edge_d  = prev_edge_q;
    avail_d      = avail_q;
    avail_out    = avail_q;

    if (item_valid_i) begin
      if (item_i.opcode == OP_RELEASE) begin
        avail_d = 1'b0;
      end else begin
        prev_edge_d = item_i.edge_time_us;
        cnt_d       = cnt_wrap;
        if (!avail_q) begin
          if (item_i.edge_level == LEVEL_FALL) begin
            if (in_range) begin
              if (is_sync) begin
                cnt_d = '0;
              end else begin
                // bits past the frame length only advance the count
                for (int unsigned i = 0; i < MessageBits; i++) begin
                  if (cnt_wrap == CNT_W'(i)) frame_d[i] = !is_zero;
                end
                cnt_d = cnt_wrap + 1'b1;
              end
            end
          end else if (is_stop) begin
            if (cnt_wrap == MsgCount) begin
              prev_ms_d = item_i.now_ms;
              if (!same_frame) prev_frame_d = frame_q;
              if (!same_frame || !repeat_hit) avail_d = 1'b1;
              else cnt_d = '0;
            end else begin
              cnt_d = '0;
            end
          end
        end
        avail_out = avail_d;
      end
    end

    result_o.frame_available = avail_out;
    for (int unsigned i = 0; i < ADDR_W; i++) begin
      result_o.address[ADDR_W-1-i] = frame_d[i];
    end
    result_o.turn_on = frame_d[ON_LSB +: ON_W] == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q      <= '0;
      prev_frame_q <= '0;
      cnt_q        <= '0;
      prev_ms_q    <= '0;
      prev_edge_q  <= '0;
      avail_q      <= 1'b0;
    end else begin
      frame_q      <= frame_d;
      prev_frame_q <= prev_frame_d;
      cnt_q        <= cnt_d;
      prev_ms_q    <= prev_ms_d;
      prev_edge_q  <= prev_edge_d;
      avail_q      <= avail_d;
    end
  end

  `PRFR_ASSERT_ALWAYS(a_cnt_bounded, cnt_q <= WrapValue)
  `PRFR_ASSERT(a_avail_from_stop,
    $rose(avail_q) |-> $past(item_valid_i && item_i.opcode == OP_EDGE && item_i.edge_level))
  `PRFR_ASSERT(a_frame_frozen, $past(avail_q) && avail_q |-> $stable(frame_q))

endmodule

// ----- design/prfr_out_queue.sv -----
// two-entry result queue between the decoder and the output port
module prfr_out_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  prfr_pkg::out_item_t  push_item_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output prfr_pkg::out_item_t  out_item_o
);
  import prfr_pkg::*;

  `include "pulse_width_rf_frame_receiver_assert.svh"

  out_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign full_o      = cnt_q == 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  `PRFR_ASSERT_ALWAYS(a_cnt_max, cnt_q <= 2'd2)
  `PRFR_ASSERT(a_no_push_full, full_o |-> !push_i)
  `PRFR_ASSERT(a_hold_stalled, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))

endmodule

// ----- design/pulse_width_rf_frame_receiver.sv -----
// pulse width remote frame receiver: each result is registered in the output queue
// throughput one item per cycle while in_stall_o is low; decoder state and result update in a single pass
// a two-entry result queue keeps taking items while fewer than two results wait
// in_stall_o rises only when both queue entries hold untaken results
// reset clears frame state and loads default thresholds; no clearing pass
module pulse_width_rf_frame_receiver #(
  parameter int unsigned MessageBits = 56,
  parameter int unsigned WrapCount   = 70
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  prfr_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output prfr_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [prfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [prfr_pkg::THR_W-1:0]      cfg_data_i
);
  import prfr_pkg::*;

  logic      accept;
  logic      full;
  out_item_t result;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  prfr_core #(
    .MessageBits(MessageBits),
    .WrapCount  (WrapCount)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_valid_i(accept),
    .item_i      (in_item_i),
    .result_o    (result)
  );

  prfr_out_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_item_i(result),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule
